// ===== rtl/core/spmf_pkg.sv =====
// spmf_pkg: shared sizes, status codes and priority encoders for the
// strict-priority multi-FIFO. No dependencies.
package spmf_pkg;

  localparam int LEVELS     = 16;
  localparam int CAPACITY   = 64;
  localparam int ELEM_WIDTH = 32;

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  localparam logic [LVL_W-1:0] LOWEST_RST = LVL_W'(LEVELS - 1);

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_LEVEL = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_EMPTY = 2'd3;

  // lowest set bit of the non-empty vector
  function automatic logic [LVL_W-1:0] first_level(input logic [LEVELS-1:0] v);
    logic [LVL_W-1:0] idx;
    idx = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (v[i]) idx = LVL_W'(i);
    end
    return idx;
  endfunction

  // lowest set bit of the free-slot bitmap
  function automatic logic [SLOT_W-1:0] first_slot(input logic [CAPACITY-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/spmf_ram.sv =====
// spmf_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
module spmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/strict_priority_multi_fifo_top.sv =====
// Strict-priority queue: one linked FIFO per level in a shared slot store.
// The result beat of an enqueue, an error, or a dequeue that empties the queue
// is set up in S_ENQ or S_DQ1; other good dequeues go on to S_DQ2 (link RAM read,
// then value RAM read). busy drops in the result strobe cycle, so no new item is
// taken before the last result; the receiver cannot stall. Synchronous active-low
// reset empties the queue and sets lowest_level to 15; slot RAMs are not cleared.
module strict_priority_multi_fifo_top
  import spmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_func,
  input  logic [ELEM_WIDTH-1:0] in_elem,
  input  logic [LVL_W-1:0]      in_level,
  output logic                  out_valid,
  output logic [ELEM_WIDTH-1:0] out_front_elem,
  output logic [LVL_W-1:0]      out_front_level,
  output logic [CNT_W-1:0]      out_count,
  output logic                  out_empty_res,
  output logic [1:0]            out_status,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ENQ  = 2'd1;
  localparam logic [1:0] S_DQ1  = 2'd2;
  localparam logic [1:0] S_DQ2  = 2'd3;

  localparam logic [1:0] ADDR_LOWEST = 2'd0;

  logic [1:0]            state_r, state_nxt;
  logic [LVL_W-1:0]      lowest_r;
  logic [LEVELS-1:0]     nonempty_r, nonempty_nxt;
  logic [CAPACITY-1:0]   free_r, free_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [ELEM_WIDTH-1:0] front_elem_r, front_elem_nxt;
  logic [LVL_W-1:0]      front_level_r, front_level_nxt;
  logic [SLOT_W-1:0]     front_slot_r, front_slot_nxt;
  logic [1:0]            status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [ELEM_WIDTH-1:0] elem_r;
  logic [LVL_W-1:0]      lvl_r;

  logic [SLOT_W-1:0]     head_r [LEVELS];
  logic [SLOT_W-1:0]     tail_r [LEVELS];

  logic                  head_we, tail_we;
  logic [LVL_W-1:0]      head_wa, tail_wa, tail_ra;
  logic [SLOT_W-1:0]     head_wd, tail_wd, tail_rd, head_rd;

  logic                  val_we, next_we;
  logic [SLOT_W-1:0]     val_waddr, val_raddr, next_waddr, next_wdata, next_rdata;
  logic [ELEM_WIDTH-1:0] val_rdata;

  logic [LEVELS-1:0]     rest_levels;
  logic [LVL_W-1:0]      f2;
  logic [SLOT_W-1:0]     s_free;
  logic                  accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign rest_levels = nonempty_r & ~(LEVELS'(1) << front_level_r);
  assign f2          = first_level(rest_levels);
  assign s_free      = first_slot(free_r);
  assign tail_ra     = (state_r == S_ENQ) ? lvl_r : front_level_r;
  assign tail_rd     = tail_r[tail_ra];
  assign head_rd     = head_r[f2];

  spmf_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (elem_r),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  spmf_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (front_slot_r),
    .rdata (next_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    nonempty_nxt    = nonempty_r;
    free_nxt        = free_r;
    count_nxt       = count_r;
    front_elem_nxt  = front_elem_r;
    front_level_nxt = front_level_r;
    front_slot_nxt  = front_slot_r;
    status_nxt      = status_r;
    out_valid_nxt   = 1'b0;
    head_we         = 1'b0;
    head_wa         = front_level_r;
    head_wd         = next_rdata;
    tail_we         = 1'b0;
    tail_wa         = lvl_r;
    tail_wd         = s_free;
    val_we          = 1'b0;
    val_waddr       = s_free;
    val_raddr       = front_slot_r;
    next_we         = 1'b0;
    next_waddr      = tail_rd;
    next_wdata      = s_free;

    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = in_func ? S_DQ1 : S_ENQ;
      end
      S_ENQ: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (lvl_r > lowest_r) begin
          status_nxt = STATUS_LEVEL;
        end else if (count_r == CNT_W'(CAPACITY)) begin
          status_nxt = STATUS_FULL;
        end else begin
          status_nxt       = STATUS_OK;
          val_we           = 1'b1;
          free_nxt[s_free] = 1'b0;
          if (nonempty_r[lvl_r]) begin
            next_we = 1'b1;
          end else begin
            head_we             = 1'b1;
            head_wa             = lvl_r;
            head_wd             = s_free;
            nonempty_nxt[lvl_r] = 1'b1;
          end
          tail_we   = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          if (count_r == '0 || lvl_r < front_level_r) begin
            front_elem_nxt  = elem_r;
            front_level_nxt = lvl_r;
            front_slot_nxt  = s_free;
          end
        end
      end
      S_DQ1: begin
        if (count_r == '0) begin
          status_nxt    = STATUS_EMPTY;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          status_nxt             = STATUS_OK;
          free_nxt[front_slot_r] = 1'b1;
          count_nxt              = count_r - CNT_W'(1);
          if (front_slot_r == tail_rd) begin
            nonempty_nxt[front_level_r] = 1'b0;
            if (|rest_levels) begin
              front_level_nxt = f2;
              front_slot_nxt  = head_rd;
              val_raddr       = head_rd;
              state_nxt       = S_DQ2;
            end else begin
              front_elem_nxt  = '0;
              front_level_nxt = '0;
              out_valid_nxt   = 1'b1;
              state_nxt       = S_IDLE;
            end
          end else begin
            head_we        = 1'b1;
            front_slot_nxt = next_rdata;
            val_raddr      = next_rdata;
            state_nxt      = S_DQ2;
          end
        end
      end
      S_DQ2: begin
        front_elem_nxt = val_rdata;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      lowest_r      <= LOWEST_RST;
      nonempty_r    <= '0;
      free_r        <= '1;
      count_r       <= '0;
      front_elem_r  <= '0;
      front_level_r <= '0;
      front_slot_r  <= '0;
      status_r      <= STATUS_OK;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      nonempty_r    <= nonempty_nxt;
      free_r        <= free_nxt;
      count_r       <= count_nxt;
      front_elem_r  <= front_elem_nxt;
      front_level_r <= front_level_nxt;
      front_slot_r  <= front_slot_nxt;
      status_r      <= status_nxt;
      out_valid_r   <= out_valid_nxt;
      if (psel && penable && pwrite) lowest_r <= pwdata[LVL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      elem_r <= in_elem;
      lvl_r  <= in_level;
    end
    if (head_we) head_r[head_wa] <= head_wd;
    if (tail_we) tail_r[tail_wa] <= tail_wd;
  end

  assign out_valid       = out_valid_r;
  assign out_front_elem  = front_elem_r;
  assign out_front_level = front_level_r;
  assign out_count       = count_r;
  assign out_empty_res   = (count_r == '0);
  assign out_status      = status_r;

  assign prdata = (paddr == ADDR_LOWEST) ? {(32 - LVL_W)'(0), lowest_r} : 32'd0;
  assign pready = 1'b1;

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for strict_priority_multi_fifo_top.
// Sends enqueue/dequeue beats, programs lowest_level over APB and mirrors the
// per-level FIFOs in a small class to check every result beat. Needs spmf_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spmf_pkg::*;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;
  localparam int REG_LOWEST = 0;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_MAX = 10;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  typedef struct packed {
    logic [ELEM_WIDTH-1:0] elem;
    logic [LVL_W-1:0]      lvl;
    logic [CNT_W-1:0]      count;
    logic                  empty;
    logic [1:0]            status;
  } front_t;

  class prio_mirror;
    logic [LVL_W-1:0]      lowest;
    logic [ELEM_WIDTH-1:0] held [LEVELS][$];
    int                    stored;
    front_t                fronts_due [$];
    int                    mismatches;

    function new();
      lowest = LOWEST_RST;
      stored = 0;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("%s", msg);
    endfunction

    // most urgent non-empty level, LEVELS when none
    function int top_level();
      int top;
      top = LEVELS;
      for (int i = LEVELS - 1; i >= 0; i--) begin
        if (held[i].size() != 0) top = i;
      end
      return top;
    endfunction

    function void take_item(logic func, logic [ELEM_WIDTH-1:0] elem,
                            logic [LVL_W-1:0] lvl);
      front_t f;
      int top;
      f = '0;
      f.status = STATUS_OK;
      if (func == FUNC_ENQ) begin
        if (lvl > lowest) begin
          f.status = STATUS_LEVEL;
        end else if (stored >= CAPACITY) begin
          f.status = STATUS_FULL;
        end else begin
          held[lvl].push_back(elem);
          stored++;
        end
      end else if (stored == 0) begin
        f.status = STATUS_EMPTY;
      end else begin
        top = top_level();
        void'(held[top].pop_front());
        stored--;
      end
      top = top_level();
      if (top < LEVELS) begin
        f.elem = held[top][0];
        f.lvl = LVL_W'(top);
      end
      f.count = CNT_W'(stored);
      f.empty = (stored == 0);
      fronts_due.push_back(f);
    endfunction

    function void check_front(front_t got);
      front_t want;
      if (fronts_due.size() == 0) begin
        flag($sformatf("unexpected result beat: elem=%h lvl=%0d cnt=%0d empty=%b st=%0d",
                       got.elem, got.lvl, got.count, got.empty, got.status));
        return;
      end
      want = fronts_due.pop_front();
      if (got !== want) begin
        flag($sformatf({"result mismatch: exp elem=%h lvl=%0d cnt=%0d empty=%b st=%0d,",
                        " got elem=%h lvl=%0d cnt=%0d empty=%b st=%0d"},
                       want.elem, want.lvl, want.count, want.empty, want.status,
                       got.elem, got.lvl, got.count, got.empty, got.status));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_func = FUNC_ENQ;
  logic [ELEM_WIDTH-1:0] in_elem = '0;
  logic [LVL_W-1:0]      in_level = '0;
  logic                  out_valid;
  logic [ELEM_WIDTH-1:0] out_front_elem;
  logic [LVL_W-1:0]      out_front_level;
  logic [CNT_W-1:0]      out_count;
  logic                  out_empty_res;
  logic [1:0]            out_status;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [1:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int         quiet_cycles = 0;
  prio_mirror mirror = new();

  strict_priority_multi_fifo_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result check, item capture and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        mirror.check_front({out_front_elem, out_front_level, out_count,
                            out_empty_res, out_status});
      end
      if (start && !busy) mirror.take_item(in_func, in_elem, in_level);
      if (out_valid || (start && !busy) || (psel && penable)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("strict_priority_multi_fifo_top regression: fail");
        $finish;
      end
    end
  end

  task automatic send(logic func, logic [ELEM_WIDTH-1:0] elem, logic [LVL_W-1:0] lvl,
                      int pct);
    int gap;
    gap = 0;
    while ($urandom_range(99) < pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= func;
    in_elem <= elem;
    in_level <= lvl;
    do @(posedge clk); while (busy);
  endtask

  // stop sending and wait out every pending result
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (mirror.fronts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_beat(logic wr, int idx, logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= 2'(4 * idx);
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_lowest(logic [LVL_W-1:0] value);
    logic [31:0] rd;
    settle();
    apb_beat(1'b1, REG_LOWEST, 32'(value), rd);
    mirror.lowest = value;
    apb_beat(1'b0, REG_LOWEST, '0, rd);
    if (rd !== 32'(value)) begin
      mirror.flag($sformatf("lowest_level readback: exp %h got %h", 32'(value), rd));
    end
  endtask

  task automatic random_run(int n, int pct);
    mix_t                  mix;
    logic                  func;
    logic [LVL_W-1:0]      lvl;
    logic [ELEM_WIDTH-1:0] elem;
    mix = MIX_EVEN;
    for (int k = 0; k < n; k++) begin
      if (k % 20 == 0) mix = mix_t'($urandom_range(2));
      case (mix)
        MIX_FILL:  func = ($urandom_range(99) < 85) ? FUNC_ENQ : FUNC_DEQ;
        MIX_DRAIN: func = ($urandom_range(99) < 85) ? FUNC_DEQ : FUNC_ENQ;
        default:   func = ($urandom_range(1) == 0) ? FUNC_ENQ : FUNC_DEQ;
      endcase
      if ($urandom_range(99) < 80) lvl = LVL_W'($urandom_range(mirror.lowest));
      else lvl = LVL_W'($urandom_range(LEVELS - 1));
      case ($urandom_range(9))
        0:       elem = '0;
        1:       elem = '1;
        default: elem = $urandom;
      endcase
      send(func, elem, lvl, pct);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty dequeue, field extremes, FIFO order within a level
    send(FUNC_DEQ, '0, '0, 0);
    send(FUNC_ENQ, 32'h0000_0000, 4'd0, 0);
    send(FUNC_ENQ, 32'hFFFF_FFFF, 4'd15, 0);
    send(FUNC_ENQ, 32'hA5A5_A5A5, 4'd7, 0);
    send(FUNC_ENQ, 32'h5A5A_5A5A, 4'd0, 0);
    repeat (4) send(FUNC_DEQ, '1, 4'd15, 0);
    send(FUNC_DEQ, '0, '0, 0);
    send(FUNC_ENQ, 32'h1234_5678, 4'd15, 0);
    send(FUNC_ENQ, 32'h9ABC_DEF0, 4'd14, 0);

    // lowered level: new ones above it rejected, stored ones still drain
    set_lowest(4'd3);
    send(FUNC_ENQ, 32'hDEAD_BEEF, 4'd4, 0);
    send(FUNC_ENQ, 32'hCAFE_F00D, 4'd15, 0);
    send(FUNC_ENQ, 32'h0F0F_0F0F, 4'd3, 0);
    send(FUNC_ENQ, 32'hF0F0_F0F0, 4'd0, 0);
    repeat (4) send(FUNC_DEQ, '0, '0, 0);
    send(FUNC_DEQ, '0, '0, 0);

    // fill to capacity, then full and level-check precedence
    set_lowest(4'd15);
    for (int k = 0; k < CAPACITY + 2; k++) begin
      send(FUNC_ENQ, $urandom, LVL_W'($urandom_range(LEVELS - 1)), 0);
    end
    set_lowest(4'd0);
    send(FUNC_ENQ, 32'h1111_1111, 4'd5, 0);
    send(FUNC_ENQ, 32'h2222_2222, 4'd0, 0);

    set_lowest(4'd15);
    random_run(95, 0);
    set_lowest(4'd0);
    random_run(95, 56);
    set_lowest(4'd9);
    random_run(95, 0);
    set_lowest(LVL_W'($urandom_range(LEVELS - 1)));
    random_run(95, 23);
    set_lowest(4'd15);
    random_run(95, 56);
    settle();

    if (mirror.mismatches == 0 && mirror.fronts_due.size() == 0) begin
      $display("strict_priority_multi_fifo_top regression: pass");
    end else begin
      $display("strict_priority_multi_fifo_top regression: fail");
    end
    $finish;
  end

endmodule
